@@ sv/tlbsa_pkg.sv @@
// shared types, constants and helpers for the bitmap slot allocator
package tlbsa_pkg;

  localparam int LINES_DEF = 64;
  localparam int SLOTS_DEF = 64;
  localparam int IDX_W     = 12;
  localparam int OFF_W     = 20;
  localparam int SIZE_W    = 8;
  localparam int CNT_W     = 13;
  localparam int FFZ_W     = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd8;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RANGE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_SPLIT,
    S_RD,
    S_UPD,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [OFF_W-1:0] offset;
  } cmd_t;

  // index of the lowest clear bit, 0 when none
  function automatic logic [5:0] ffz(input logic [FFZ_W-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = FFZ_W - 1; i >= 0; i--) begin
      if (!v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

@@ sv/tlbsa_div.sv @@
// restoring serial divider, one quotient bit per cycle
module tlbsa_div
  import tlbsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OFF_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [OFF_W-1:0]  quot
);

  localparam int STEP_W = $clog2(OFF_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [OFF_W-1:0]  q;
  logic [SIZE_W-1:0] r;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {r, q[OFF_W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        q    <= dividend;
        r    <= '0;
      end else if (busy) begin
        r    <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        q    <= {q[OFF_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(OFF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

@@ sv/tlbsa_front.sv @@
// request intake: classify each request and queue it for the engine
module tlbsa_front
  import tlbsa_pkg::*;
#(
  parameter int LINES          = LINES_DEF,
  parameter int SLOTS_PER_LINE = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        func,
  input  logic [OFF_W-1:0]  byte_offset,
  input  logic [SIZE_W-1:0] object_size,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output cmd_t              cmd
);

  localparam int POOL_SLOTS = LINES * SLOTS_PER_LINE;

  cmd_t        slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [OFF_W:0] limit;
  cmd_t        in_cmd;
  logic        push;
  logic        pop;

  always_comb begin
    limit         = (OFF_W+1)'(POOL_SLOTS) * (OFF_W+1)'(object_size);
    in_cmd.offset = byte_offset;
    case (func_t'(func))
      FUNC_ALLOC: in_cmd.op = OP_ALLOC;
      FUNC_FREE: begin
        if (object_size == '0 || {1'b0, byte_offset} >= limit) in_cmd.op = OP_RANGE;
        else in_cmd.op = OP_FREE;
      end
      FUNC_CLEAR: in_cmd.op = OP_CLEAR;
      default:    in_cmd.op = OP_NOP;
    endcase
  end

  assign req_ready = count != 2'd2;
  assign push      = req_valid && req_ready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = count != 2'd0;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= in_cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ sv/tlbsa_back.sv @@
// allocation engine: line bitmaps, full mask, used count and result register
module tlbsa_back
  import tlbsa_pkg::*;
#(
  parameter int LINES          = LINES_DEF,
  parameter int SLOTS_PER_LINE = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] object_size,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [IDX_W-1:0]  slot_index,
  output logic [OFF_W-1:0]  slot_offset,
  output logic [1:0]        status,
  output logic              full_flag,
  output logic              empty_flag
);

  localparam int LW = $clog2(LINES);
  localparam int PW = $clog2(SLOTS_PER_LINE);
  localparam logic [IDX_W-1:0] SPL = IDX_W'(SLOTS_PER_LINE);
  // reciprocal of the line length, exact for every slot index below 4096
  localparam int RK = 20;
  localparam logic [17:0] RECIP = 18'((1 << RK) / SLOTS_PER_LINE + 1);

  state_t state, state_next;

  logic [SLOTS_PER_LINE-1:0] mem [LINES];
  logic [SLOTS_PER_LINE-1:0] rd_q;
  logic [LINES-1:0]          line_valid;
  logic [LINES-1:0]          full_lines;
  logic [CNT_W-1:0]          used_count;

  logic              is_alloc;
  logic [LW-1:0]     ln;
  logic [PW-1:0]     pos;
  logic [IDX_W-1:0]  idx;
  logic [OFF_W-1:0]  res_off;
  status_t           res_st;

  logic              div_start;
  logic [OFF_W-1:0]  div_dividend;
  logic [SIZE_W-1:0] div_divisor;
  logic              div_done;
  logic [OFF_W-1:0]  div_quot;

  logic              mem_rd;
  logic [LW-1:0]     rd_addr;
  logic              out_load;

  logic [FFZ_W-1:0]          full_pad;
  logic                      any_free;
  logic [LW-1:0]             free_line;
  logic [SLOTS_PER_LINE-1:0] line_data;
  logic [FFZ_W-1:0]          line_pad;
  logic [PW-1:0]             alloc_pos;
  logic [SLOTS_PER_LINE-1:0] line_set;
  logic [SLOTS_PER_LINE-1:0] line_clr;
  logic [29:0]               split_prod;
  logic [LW-1:0]             split_ln;

  tlbsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // search helpers
  always_comb begin
    full_pad             = '1;
    full_pad[LINES-1:0]  = full_lines;
    any_free             = !(&full_lines);
    free_line            = LW'(ffz(full_pad));
    line_data            = line_valid[ln] ? rd_q : '0;
    line_pad             = '1;
    line_pad[SLOTS_PER_LINE-1:0] = line_data;
    alloc_pos            = PW'(ffz(line_pad));
    line_set             = line_data | (SLOTS_PER_LINE'(1) << alloc_pos);
    line_clr             = line_data & ~(SLOTS_PER_LINE'(1) << pos);
    split_prod           = 30'(idx) * 30'(RECIP);
    split_ln             = LW'(split_prod >> RK);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ALLOC: state_next = any_free ? S_UPD : S_OUT;
            OP_FREE:  state_next = S_DIV1;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_DIV1:  if (div_done) state_next = S_SPLIT;
      S_SPLIT: state_next = S_RD;
      S_RD:    state_next = S_UPD;
      S_UPD:   state_next = S_MUL;
      S_MUL:   state_next = S_OUT;
      S_OUT:   if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop      = 1'b0;
    div_start    = 1'b0;
    div_dividend = cmd.offset;
    div_divisor  = object_size;
    mem_rd       = 1'b0;
    rd_addr      = ln;
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid && cmd.op == OP_FREE) div_start = 1'b1;
        if (cmd_valid && cmd.op == OP_ALLOC && any_free) begin
          mem_rd  = 1'b1;
          rd_addr = free_line;
        end
      end
      S_RD:    mem_rd = 1'b1;
      S_OUT:   out_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_rd) rd_q <= mem[rd_addr];
    if (state == S_UPD && (is_alloc || line_data[pos])) begin
      mem[ln] <= is_alloc ? line_set : line_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      line_valid <= '0;
      full_lines <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            is_alloc <= cmd.op == OP_ALLOC;
            ln       <= free_line;
            idx      <= '0;
            res_off  <= '0;
            case (cmd.op)
              OP_ALLOC: res_st <= any_free ? ST_OK : ST_FULL;
              OP_RANGE: res_st <= ST_RANGE;
              OP_CLEAR: begin
                res_st     <= ST_OK;
                line_valid <= '0;
                full_lines <= '0;
                used_count <= '0;
              end
              default:  res_st <= ST_OK;
            endcase
          end
        end
        S_DIV1:  if (div_done) idx <= div_quot[IDX_W-1:0];
        S_SPLIT: ln <= split_ln;
        S_RD:    pos <= PW'(idx - IDX_W'(ln) * SPL);
        S_UPD: begin
          if (is_alloc) begin
            line_valid[ln] <= 1'b1;
            if (&line_set) full_lines[ln] <= 1'b1;
            used_count <= used_count + 1'b1;
            idx        <= IDX_W'(ln) * SPL + IDX_W'(alloc_pos);
            res_st     <= ST_OK;
          end else if (line_data[pos]) begin
            line_valid[ln] <= 1'b1;
            full_lines[ln] <= 1'b0;
            used_count     <= used_count - 1'b1;
            res_st         <= ST_OK;
          end else begin
            res_st <= ST_UNUSED;
          end
        end
        S_MUL: res_off <= OFF_W'(idx) * OFF_W'(object_size);
        default: ;
      endcase
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_index  <= idx;
      slot_offset <= res_off;
      status      <= res_st;
      full_flag   <= &full_lines;
      empty_flag  <= used_count == '0;
    end
  end

endmodule

@@ sv/two_level_bitmap_slot_allocator.sv @@
// from input transfer to result valid: allocate searches, updates and scales; clear/out-of-range/full load the result
// free: 20-step serial divide of offset by size, then line split and bitmap update
// one request is worked at a time; a two-entry queue and the result register decouple ports
// reset: synchronous, clears bitmaps (per-line valid bits), full mask, count, size to 8
module two_level_bitmap_slot_allocator
  import tlbsa_pkg::*;
#(
  parameter int LINES          = LINES_DEF,
  parameter int SLOTS_PER_LINE = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // size register write
  input  logic              object_size_we,
  input  logic [SIZE_W-1:0] object_size_data,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        func,
  input  logic [OFF_W-1:0]  byte_offset,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [IDX_W-1:0]  slot_index,
  output logic [OFF_W-1:0]  slot_offset,
  output logic [1:0]        status,
  output logic              full_flag,
  output logic              empty_flag
);

  logic [SIZE_W-1:0] object_size;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  // bytes per slot; the user must change it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) object_size <= SIZE_RESET;
    else if (object_size_we) object_size <= object_size_data;
  end

  // front: classify and queue each transfer
  tlbsa_front #(
    .LINES          (LINES),
    .SLOTS_PER_LINE (SLOTS_PER_LINE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .byte_offset (byte_offset),
    .object_size (object_size),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd)
  );

  // back: bitmap search/update, divide and scale, result register
  tlbsa_back #(
    .LINES          (LINES),
    .SLOTS_PER_LINE (SLOTS_PER_LINE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .object_size (object_size),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .slot_index  (slot_index),
    .slot_offset (slot_offset),
    .status      (status),
    .full_flag   (full_flag),
    .empty_flag  (empty_flag)
  );

endmodule
